>>> hw/rtl/rcr_pkg.sv
// Shared types and constants for the RNS CRT reconstruction block.
// Holds the datapath operation codes and the controller/datapath command
// and status structs. No dependencies.
package rcr_pkg;

    localparam int MAX_LEVELS = 7;
    localparam int W_Q        = 62;    // modulus and residue width
    localparam int W_ACC      = 128;   // accumulator and running product width
    localparam int W_WORD     = 64;    // output word width
    localparam int W_WM       = W_ACC + W_Q;  // exact product width
    localparam int W_IDX      = 3;
    localparam int W_CNT      = 8;
    localparam int W_STATUS   = 2;

    localparam logic [W_STATUS-1:0] STATUS_OK     = 2'd0;
    localparam logic [W_STATUS-1:0] STATUS_NO_INV = 2'd1;
    localparam logic [W_STATUS-1:0] STATUS_OVER   = 2'd2;

    localparam logic [W_IDX-1:0] REG_LEVEL_COUNT = 3'd0;

    // Bit-serial pass lengths
    localparam logic [W_CNT-1:0] RED_STEPS = 8'd128;
    localparam logic [W_CNT-1:0] Q_STEPS   = 8'd62;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,       // latch residue and modulus of the level
        OP_LOAD_FIRST,   // first level: load accumulator and product
        OP_ERR_INV,      // flag not invertible, digit zero
        OP_RED_P_START,  // reduce product mod q
        OP_RED_STEP,
        OP_EUC_INIT,     // start extended Euclid on (q, P mod q)
        OP_DIV_START,
        OP_DIV_STEP,
        OP_EUC_UPD,
        OP_INV_TAKE,     // keep inverse, start reducing accumulator
        OP_RED_D_START,  // reduce residue difference
        OP_MM_START,
        OP_MM_STEP,
        OP_K_TAKE,
        OP_WMK_START,
        OP_WM_STEP,
        OP_ACC_ADD,      // add P*k, start P*q
        OP_PROD_UPD,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [W_IDX-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic cnt_last;
        logic q_small;
        logic e1_zero;
        logic e0_one;
        logic last_level;
    } t_sts;

endpackage

>>> hw/rtl/rcr_datapath.sv
// Datapath of the RNS CRT reconstruction: configuration registers, the
// bit-serial reducer, divider, modular multiplier and wide multiplier.
// Depends on rcr_pkg.
module rcr_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_index,
    input  logic [61:0]               i_cfg_data,
    input  logic [61:0]               i_residue,
    input  rcr_pkg::t_cmd             i_cmd,
    output rcr_pkg::t_sts             o_sts,
    output logic [63:0]               o_value_low,
    output logic [63:0]               o_value_high,
    output logic [1:0]                o_status
);
    import rcr_pkg::*;

    logic [W_IDX-1:0]    r_num_levels;
    logic [W_Q-1:0]      r_moduli [MAX_LEVELS];

    logic [W_Q-1:0]      r_res, r_q;
    logic [W_ACC-1:0]    r_acc, r_prod;
    logic [W_STATUS-1:0] r_err;
    logic [W_CNT-1:0]    r_cnt;
    logic [W_ACC-1:0]    r_red_src;
    logic [W_Q-1:0]      r_red_r;
    logic [W_Q-1:0]      r_e0, r_e1, r_t0, r_t1, r_rem, r_s, r_add, r_inv, r_k;
    logic [W_Q-1:0]      r_bits;
    logic [W_WM-1:0]     r_wm;
    logic [W_WORD-1:0]   r_out_low, r_out_high;
    logic [W_STATUS-1:0] r_out_status;

    logic [W_Q:0]        red_sh, n_red;
    logic [W_Q:0]        div_sh, n_div;
    logic                div_ge;
    logic                mm_bit;
    logic [W_Q:0]        s2, s2r, s3, s3r;
    logic [W_Q:0]        tn, tnr;
    logic [W_Q:0]        diff_src;
    logic [W_WM-1:0]     n_wm;
    logic                wm_over;
    logic [W_IDX-1:0]    n_levels;
    logic [W_IDX:0]      idx_next;

    // Reducer step: shift in one bit, subtract q once
    assign red_sh = {r_red_r, r_red_src[W_ACC-1]};
    assign n_red  = (red_sh >= {1'b0, r_q}) ? red_sh - {1'b0, r_q} : red_sh;

    // Restoring division step of the Euclid quotient
    assign div_sh = {r_rem, r_bits[W_Q-1]};
    assign div_ge = (div_sh >= {1'b0, r_e1});
    assign n_div  = div_ge ? div_sh - {1'b0, r_e1} : div_sh;

    // Horner modular multiply-accumulate: s = 2s + bit*add mod q
    assign mm_bit = (i_cmd.op == OP_DIV_STEP) ? div_ge : r_bits[W_Q-1];
    assign s2  = {r_s, 1'b0};
    assign s2r = (s2 >= {1'b0, r_q}) ? s2 - {1'b0, r_q} : s2;
    assign s3  = mm_bit ? {1'b0, s2r[W_Q-1:0]} + {1'b0, r_add} : s2r;
    assign s3r = (s3 >= {1'b0, r_q}) ? s3 - {1'b0, r_q} : s3;

    // Euclid coefficient update: t0 - qt*t1 mod q
    assign tn  = {1'b0, r_t0} + {1'b0, r_q} - {1'b0, r_s};
    assign tnr = (tn >= {1'b0, r_q}) ? tn - {1'b0, r_q} : tn;

    assign diff_src = {1'b0, r_res} + {1'b0, r_q} - {1'b0, r_red_r};

    // Wide multiply step over the bits of the multiplier, MSB first
    assign n_wm    = {r_wm[W_WM-2:0], 1'b0}
                   + (r_bits[W_Q-1] ? {{W_Q{1'b0}}, r_prod} : {W_WM{1'b0}});
    assign wm_over = (|r_wm[W_WM-1:W_ACC])
                   || (r_wm[W_ACC-1] && (|r_wm[W_ACC-2:0]));

    assign n_levels = (r_num_levels == '0) ? W_IDX'(1) : r_num_levels;
    assign idx_next = {1'b0, i_cmd.idx} + (W_IDX+1)'(1);

    assign o_sts.cnt_last   = (r_cnt == W_CNT'(1));
    assign o_sts.q_small    = (r_q < W_Q'(2));
    assign o_sts.e1_zero    = (r_e1 == '0);
    assign o_sts.e0_one     = (r_e0 == W_Q'(1));
    assign o_sts.last_level = (idx_next >= {1'b0, n_levels});

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_levels <= W_IDX'(1);
            r_moduli[0] <= W_Q'(3);
            r_moduli[1] <= W_Q'(5);
            r_moduli[2] <= W_Q'(7);
            r_moduli[3] <= W_Q'(11);
            r_moduli[4] <= W_Q'(13);
            r_moduli[5] <= W_Q'(17);
            r_moduli[6] <= W_Q'(19);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_LEVEL_COUNT) begin
                r_num_levels <= i_cfg_data[W_IDX-1:0];
            end else begin
                r_moduli[i_cfg_index - W_IDX'(1)] <= i_cfg_data;
            end
        end
    end

    // Error code: keep the first error of a coefficient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= STATUS_OK;
        end else begin
            case (i_cmd.op)
                OP_LOAD_FIRST: r_err <= STATUS_OK;
                OP_ERR_INV: begin
                    if (r_err == STATUS_OK) r_err <= STATUS_NO_INV;
                end
                OP_PROD_UPD: begin
                    if (r_err == STATUS_OK && wm_over) r_err <= STATUS_OVER;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers, advanced by the controller's operation
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_res <= i_residue;
                r_q   <= r_moduli[i_cmd.idx];
            end
            OP_LOAD_FIRST: begin
                r_acc  <= {{(W_ACC-W_Q){1'b0}}, r_res};
                r_prod <= {{(W_ACC-W_Q){1'b0}}, r_moduli[0]};
            end
            OP_ERR_INV: r_k <= '0;
            OP_RED_P_START: begin
                r_red_src <= r_prod;
                r_red_r   <= '0;
                r_cnt     <= RED_STEPS;
            end
            OP_RED_STEP: begin
                r_red_src <= {r_red_src[W_ACC-2:0], 1'b0};
                r_red_r   <= n_red[W_Q-1:0];
                r_cnt     <= r_cnt - W_CNT'(1);
            end
            OP_EUC_INIT: begin
                r_e0 <= r_q;
                r_e1 <= r_red_r;
                r_t0 <= '0;
                r_t1 <= W_Q'(1);
            end
            OP_DIV_START: begin
                r_rem  <= '0;
                r_bits <= r_e0;
                r_s    <= '0;
                r_add  <= r_t1;
                r_cnt  <= Q_STEPS;
            end
            OP_DIV_STEP: begin
                r_rem  <= n_div[W_Q-1:0];
                r_bits <= {r_bits[W_Q-2:0], 1'b0};
                r_s    <= s3r[W_Q-1:0];
                r_cnt  <= r_cnt - W_CNT'(1);
            end
            OP_EUC_UPD: begin
                r_e0 <= r_e1;
                r_e1 <= r_rem;
                r_t0 <= r_t1;
                r_t1 <= tnr[W_Q-1:0];
            end
            OP_INV_TAKE: begin
                r_inv     <= r_t0;
                r_red_src <= r_acc;
                r_red_r   <= '0;
                r_cnt     <= RED_STEPS;
            end
            OP_RED_D_START: begin
                r_red_src <= {{(W_ACC-W_Q-1){1'b0}}, diff_src};
                r_red_r   <= '0;
                r_cnt     <= RED_STEPS;
            end
            OP_MM_START: begin
                r_bits <= r_red_r;
                r_add  <= r_inv;
                r_s    <= '0;
                r_cnt  <= Q_STEPS;
            end
            OP_MM_STEP: begin
                r_bits <= {r_bits[W_Q-2:0], 1'b0};
                r_s    <= s3r[W_Q-1:0];
                r_cnt  <= r_cnt - W_CNT'(1);
            end
            OP_K_TAKE: r_k <= r_s;
            OP_WMK_START: begin
                r_bits <= r_k;
                r_wm   <= '0;
                r_cnt  <= Q_STEPS;
            end
            OP_WM_STEP: begin
                r_bits <= {r_bits[W_Q-2:0], 1'b0};
                r_wm   <= n_wm;
                r_cnt  <= r_cnt - W_CNT'(1);
            end
            OP_ACC_ADD: begin
                r_acc  <= r_acc + r_wm[W_ACC-1:0];
                r_bits <= r_q;
                r_wm   <= '0;
                r_cnt  <= Q_STEPS;
            end
            OP_PROD_UPD: r_prod <= r_wm[W_ACC-1:0];
            OP_EMIT: begin
                r_out_low    <= r_acc[W_WORD-1:0];
                r_out_high   <= r_acc[W_ACC-1:W_WORD];
                r_out_status <= r_err;
            end
            default: ;
        endcase
    end

    assign o_value_low  = r_out_low;
    assign o_value_high = r_out_high;
    assign o_status     = r_out_status;

endmodule

>>> hw/rtl/rcr_ctrl.sv
// Controller of the RNS CRT reconstruction: sequences the datapath passes
// for each residue and runs both handshakes. Depends on rcr_pkg.
module rcr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_residue_valid,
    output logic          o_residue_stall,
    output logic          o_result_valid,
    input  logic          i_result_stall,
    input  rcr_pkg::t_sts i_sts,
    output rcr_pkg::t_cmd o_cmd
);
    import rcr_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE     = 20'h00001,
        S_FIRST    = 20'h00002,
        S_CHECK    = 20'h00004,
        S_RED_P    = 20'h00008,
        S_EUC_INIT = 20'h00010,
        S_EUC_TEST = 20'h00020,
        S_DIV      = 20'h00040,
        S_EUC_UPD  = 20'h00080,
        S_RED_A    = 20'h00100,
        S_RED_D0   = 20'h00200,
        S_RED_D    = 20'h00400,
        S_MM0      = 20'h00800,
        S_MM       = 20'h01000,
        S_K        = 20'h02000,
        S_WMK      = 20'h04000,
        S_WM_K     = 20'h08000,
        S_ACC      = 20'h10000,
        S_WM_Q     = 20'h20000,
        S_PROD     = 20'h40000,
        S_EMIT     = 20'h80000
    } t_state;

    t_state           r_state, n_state;
    logic [W_IDX-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    t_op              op;

    assign out_free        = !r_out_valid || !i_result_stall;
    assign o_residue_stall = (r_state != S_IDLE);
    assign o_result_valid  = r_out_valid;
    assign o_cmd.op        = op;
    assign o_cmd.idx       = r_idx;

    // Next state and datapath operation
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_result_stall;
        op          = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_residue_valid) begin
                    op      = OP_ACCEPT;
                    n_state = (r_idx == '0) ? S_FIRST : S_CHECK;
                end
            end
            S_FIRST: begin
                op      = OP_LOAD_FIRST;
                n_state = S_EMIT;
            end
            S_CHECK: begin
                if (i_sts.q_small) begin
                    op      = OP_ERR_INV;
                    n_state = S_WMK;
                end else begin
                    op      = OP_RED_P_START;
                    n_state = S_RED_P;
                end
            end
            S_RED_P: begin
                op = OP_RED_STEP;
                if (i_sts.cnt_last) n_state = S_EUC_INIT;
            end
            S_EUC_INIT: begin
                op      = OP_EUC_INIT;
                n_state = S_EUC_TEST;
            end
            S_EUC_TEST: begin
                if (!i_sts.e1_zero) begin
                    op      = OP_DIV_START;
                    n_state = S_DIV;
                end else if (i_sts.e0_one) begin
                    op      = OP_INV_TAKE;
                    n_state = S_RED_A;
                end else begin
                    op      = OP_ERR_INV;
                    n_state = S_WMK;
                end
            end
            S_DIV: begin
                op = OP_DIV_STEP;
                if (i_sts.cnt_last) n_state = S_EUC_UPD;
            end
            S_EUC_UPD: begin
                op      = OP_EUC_UPD;
                n_state = S_EUC_TEST;
            end
            S_RED_A: begin
                op = OP_RED_STEP;
                if (i_sts.cnt_last) n_state = S_RED_D0;
            end
            S_RED_D0: begin
                op      = OP_RED_D_START;
                n_state = S_RED_D;
            end
            S_RED_D: begin
                op = OP_RED_STEP;
                if (i_sts.cnt_last) n_state = S_MM0;
            end
            S_MM0: begin
                op      = OP_MM_START;
                n_state = S_MM;
            end
            S_MM: begin
                op = OP_MM_STEP;
                if (i_sts.cnt_last) n_state = S_K;
            end
            S_K: begin
                op      = OP_K_TAKE;
                n_state = S_WMK;
            end
            S_WMK: begin
                op      = OP_WMK_START;
                n_state = S_WM_K;
            end
            S_WM_K: begin
                op = OP_WM_STEP;
                if (i_sts.cnt_last) n_state = S_ACC;
            end
            S_ACC: begin
                op      = OP_ACC_ADD;
                n_state = S_WM_Q;
            end
            S_WM_Q: begin
                op = OP_WM_STEP;
                if (i_sts.cnt_last) n_state = S_PROD;
            end
            S_PROD: begin
                op      = OP_PROD_UPD;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // On the last level, hold until the output register can take the result
                if (i_sts.last_level) begin
                    if (out_free) begin
                        op          = OP_EMIT;
                        n_out_valid = 1'b1;
                        n_idx       = '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_idx   = r_idx + W_IDX'(1);
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hw/rtl/rns_crt_reconstruct.sv
// Top level of the RNS CRT reconstruction block.
// Instantiates rcr_ctrl and rcr_datapath; depends on rcr_pkg.
//
// Residues of one coefficient enter one transaction at a time in level
// order; after the programmed number of levels one result transaction
// carries the 128-bit value and its status. The first residue of a
// coefficient only loads the accumulator and running product. Each later
// one needs E extended-Euclid steps for the inverse of the running
// product (at most about 90 for 62-bit moduli), and a bit-serial
// reducer makes three 128-step passes (product, accumulator, difference),
// the modular multiplier and the wide multiplier make 62-step passes, and
// each Euclid step is a 62-step serial division. A new residue is taken
// only when the previous one is finished; a finished result may wait in
// the output register meanwhile, and the last residue of the next
// coefficient holds until that register is free.
module rns_crt_reconstruct (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [61:0] i_cfg_data,
    input  logic        i_residue_valid,
    output logic        o_residue_stall,
    input  logic [61:0] i_residue,
    output logic        o_result_valid,
    input  logic        i_result_stall,
    output logic [63:0] o_value_low,
    output logic [63:0] o_value_high,
    output logic [1:0]  o_status
);
    import rcr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence the passes per residue
    rcr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_residue_valid (i_residue_valid),
        .o_residue_stall (o_residue_stall),
        .o_result_valid  (o_result_valid),
        .i_result_stall  (i_result_stall),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    // Arithmetic and configuration
    rcr_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_residue    (i_residue),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_value_low  (o_value_low),
        .o_value_high (o_value_high),
        .o_status     (o_status)
    );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for rns_crt_reconstruct (CRT reconstruction of a coefficient).
// Depends on rcr_pkg for status codes and the level-count register index.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rcr_pkg::*;

    localparam int SETTLE_CYCLES = 7000;   // worst-case work on one residue
    localparam int RANDOM_ITEMS  = 1950;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [1:0]  st;
    } coeff_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [61:0] i_cfg_data = '0;
    logic        i_residue_valid = 1'b0;
    logic        o_residue_stall;
    logic [61:0] i_residue = '0;
    logic        o_result_valid;
    logic        i_result_stall = 1'b0;
    logic [63:0] o_value_low;
    logic [63:0] o_value_high;
    logic [1:0]  o_status;

    rns_crt_reconstruct u_top (.*);

    always #10 i_clk = ~i_clk;

    // Mirror of the block: configuration and reconstruction state
    logic [2:0]   level_cnt = 3'd1;
    logic [61:0]  moduli [7] = '{62'd3, 62'd5, 62'd7, 62'd11, 62'd13, 62'd17, 62'd19};
    logic [127:0] acc = '0;
    logic [127:0] prod = 128'd1;
    logic [2:0]   lvl = '0;
    logic [1:0]   err = STATUS_OK;

    coeff_t expected_coeffs[$];
    int     errors = 0;
    int     sent = 0;
    bit     no_gaps = 0;
    int     hold_left = 0;

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 16);
    endfunction

    // Extended Euclid; returns 1 when a has an inverse mod q
    function automatic bit mod_inverse(logic [127:0] a, logic [127:0] q,
                                       output logic [127:0] inv);
        logic [127:0] r0, r1, t0, t1, qt, rn, tn;
        r0 = q; r1 = a; t0 = 0; t1 = 1;
        while (r1 != 0) begin
            qt = r0 / r1;
            rn = r0 - qt * r1;
            tn = (t0 + q - ((qt % q) * t1) % q) % q;
            r0 = r1; r1 = rn;
            t0 = t1; t1 = tn;
        end
        inv = t0;
        return r0 == 1;
    endfunction

    function automatic void flag_error(logic [1:0] code);
        if (err == STATUS_OK) err = code;
    endfunction

    // Advance the mirror by one residue; queue a coefficient when it completes
    function automatic void reconstruct_step(logic [61:0] res);
        logic [2:0]   n, idx;
        logic [127:0] q, k, inv, r, diff;
        logic [191:0] wide;
        n = (level_cnt == 0) ? 3'd1 : level_cnt;
        idx = (lvl >= 3'd7) ? 3'd6 : lvl;
        if (idx == 0) begin
            acc = {66'b0, res};
            prod = {66'b0, moduli[0]};
            err = STATUS_OK;
        end else begin
            q = {66'b0, moduli[idx]};
            k = 0;
            if (q < 2) begin
                flag_error(STATUS_NO_INV);
            end else if (!mod_inverse(prod % q, q, inv)) begin
                flag_error(STATUS_NO_INV);
            end else begin
                r = acc % q;
                diff = ({66'b0, res} + q - r) % q;
                k = (diff * inv) % q;
            end
            acc = acc + prod * k;
            wide = {64'b0, prod} * {64'b0, q};
            if (wide > (192'd1 << 127)) flag_error(STATUS_OVER);
            prod = wide[127:0];
        end
        if (idx + 1 >= n) begin
            expected_coeffs.push_back('{acc[63:0], acc[127:64], err});
            lvl = 0;
        end else begin
            lvl = 3'(idx + 1);
        end
    endfunction

    // Result side: random stall per transaction, compare against oldest expectation
    always @(posedge i_clk) begin
        coeff_t e;
        if (i_rst_n) begin
            if (o_result_valid && !i_result_stall) begin
                if (expected_coeffs.size() == 0) begin
                    $display("%0t: unexpected result lo=%h hi=%h st=%0d", $time,
                             o_value_low, o_value_high, o_status);
                    errors++;
                end else begin
                    e = expected_coeffs.pop_front();
                    if (o_value_low !== e.lo) begin
                        $display("%0t: value_low expected %h actual %h", $time, e.lo,
                                 o_value_low);
                        errors++;
                    end
                    if (o_value_high !== e.hi) begin
                        $display("%0t: value_high expected %h actual %h", $time, e.hi,
                                 o_value_high);
                        errors++;
                    end
                    if (o_status !== e.st) begin
                        $display("%0t: status expected %0d actual %0d", $time, e.st,
                                 o_status);
                        errors++;
                    end
                end
                hold_left = draw_gap();
                i_result_stall <= (hold_left != 0);
            end else if (hold_left > 0) begin
                hold_left--;
                i_result_stall <= (hold_left != 0);
            end
        end
    end

    // Send one residue; valid stays high so a back-to-back transaction needs no gap
    task automatic send_residue(logic [61:0] res);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_residue_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_residue_valid <= 1'b1;
        i_residue <= res;
        do @(posedge i_clk); while (o_residue_stall);
        reconstruct_step(res);
        sent++;
    endtask

    // Drop valid and wait until the block has nothing left to do
    task automatic drain();
        @(posedge i_clk);
        i_residue_valid <= 1'b0;
        while (expected_coeffs.size() != 0) @(posedge i_clk);
        if (lvl != 0) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [61:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        if (index == REG_LEVEL_COUNT) level_cnt = data[2:0];
        else moduli[index - 1] = data;
    endtask

    task automatic close_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_reg(logic [2:0] index, logic [61:0] data);
        write_reg(index, data);
        close_writes();
    endtask

    function automatic logic [61:0] rand62();
        return 62'({$urandom, $urandom});
    endfunction

    function automatic logic [61:0] draw_modulus();
        case ($urandom_range(0, 6))
            0: return rand62();
            1: return 62'($urandom_range(2, 1000));
            2: return {62{1'b1}};
            3: return 62'd2;
            4: return {30'b0, $urandom};
            5: return rand62() | 62'd1;
            default: return 62'({$urandom_range(0, 255), $urandom}) | 62'd1;
        endcase
    endfunction

    function automatic logic [61:0] draw_residue(logic [61:0] q);
        if (q >= 2 && $urandom_range(0, 3) != 0) return rand62() % q;
        return rand62();
    endfunction

    // Send a whole coefficient at the current level count
    task automatic send_coefficient();
        int n;
        logic [2:0] i;
        n = (level_cnt == 0) ? 1 : level_cnt;
        for (int j = 0; j < n; j++) begin
            i = 3'(j);
            send_residue(draw_residue(moduli[i]));
        end
    endtask

    task automatic test_reset_defaults();
        send_residue(62'd0);
        send_residue({62{1'b1}});
        send_residue(62'h2AAA_AAAA_AAAA_AAAA);
        drain();
    endtask

    task automatic test_small_moduli();
        set_reg(REG_LEVEL_COUNT, 62'd7);
        // seven ordinary residues, then an unreduced set
        for (int j = 0; j < 7; j++) send_residue(62'(j + 1));
        for (int j = 0; j < 7; j++) send_residue({62{1'b1}} - 62'(j));
        drain();
    endtask

    task automatic test_error_cases();
        // shared factor between moduli: not invertible
        set_reg(3'd2, 62'd6);
        for (int j = 0; j < 7; j++) send_residue(62'(j));
        drain();
        // modulus zero and one at later levels
        set_reg(3'd2, 62'd5);
        set_reg(3'd3, 62'd1);
        set_reg(3'd4, 62'd0);
        for (int j = 0; j < 7; j++) send_residue(62'(j));
        drain();
        // huge moduli: product overflow, then overflow after a non-inverse
        for (int r = 1; r < 8; r++) write_reg(3'(r), {62{1'b1}} - 62'(2 * r));
        close_writes();
        for (int j = 0; j < 7; j++) send_residue(rand62());
        drain();
        set_reg(3'd2, 62'd0);
        for (int j = 0; j < 7; j++) send_residue(rand62());
        drain();
    endtask

    task automatic test_num_levels_edges();
        for (int r = 1; r < 8; r++) write_reg(3'(r), 62'd97 + 62'(4 * r));
        write_reg(REG_LEVEL_COUNT, 62'd0);
        close_writes();
        send_residue(62'd5);
        drain();
        // lower the count while a coefficient is half done
        set_reg(REG_LEVEL_COUNT, 62'd7);
        send_residue(62'd11);
        send_residue(62'd12);
        send_residue(62'd13);
        drain();
        set_reg(REG_LEVEL_COUNT, 62'd2);
        send_residue(62'd14);
        drain();
    endtask

    task automatic test_random();
        while (sent < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            for (int r = 1; r < 8; r++) write_reg(3'(r), draw_modulus());
            write_reg(REG_LEVEL_COUNT, $urandom_range(0, 9) == 0 ? 62'd0
                                                               : 62'($urandom_range(1, 7)));
            close_writes();
            repeat ($urandom_range(3, 12)) send_coefficient();
            // occasional stray residue before the next phase
            if ($urandom_range(0, 3) == 0) begin
                send_residue(rand62());
                drain();
                set_reg(REG_LEVEL_COUNT, 62'($urandom_range(1, 7)));
                send_coefficient();
            end
            drain();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_small_moduli();
        test_error_cases();
        test_num_levels_edges();
        test_random();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_coeffs.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        repeat (150) #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/rcr_pkg.sv
hw/rtl/rcr_datapath.sv
hw/rtl/rcr_ctrl.sv
hw/rtl/rns_crt_reconstruct.sv
verif/testbench.sv
